// ===== design/clpw_pkg.sv =====
`timescale 1ns / 1ps
package clpw_pkg;

  typedef enum logic [1:0] {
    CUR_NONE,
    CUR_LINE1,
    CUR_LINE2
  } cursor_e;

  typedef struct packed {
    logic       init;
    cursor_e    cursor;
    logic [7:0] ch;
  } desc_t;

  typedef struct packed {
    logic  empty;
    desc_t head;
  } q_stat_t;

  typedef logic [3:0] nib_idx_t;

  // Nibble slots of one character's run
  localparam nib_idx_t NIB_INIT_FIRST  = 4'd0;
  localparam nib_idx_t NIB_INIT_LAST   = 4'd2;
  localparam nib_idx_t NIB_SETUP_FIRST = 4'd3;
  localparam nib_idx_t NIB_SETUP_LAST  = 4'd10;
  localparam nib_idx_t NIB_CURSOR_HI   = 4'd11;
  localparam nib_idx_t NIB_CURSOR_LO   = 4'd12;
  localparam nib_idx_t NIB_DATA_HI     = 4'd13;
  localparam nib_idx_t NIB_DATA_LO     = 4'd14;

  localparam logic [7:0] SETUP_CMDS [4] = '{8'h28, 8'h0C, 8'h01, 8'h06};
  localparam logic [3:0] INIT_NIB_A = 4'h3;
  localparam logic [3:0] INIT_NIB_B = 4'h2;
  localparam logic [7:0] CMD_LINE1  = 8'h80;
  localparam logic [7:0] CMD_LINE2  = 8'hC0;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  function automatic logic [3:0] nib_value(nib_idx_t idx, cursor_e cur, logic [7:0] ch);
    nib_idx_t   sel;
    logic [7:0] cbyte;
    logic [7:0] sbyte;
    logic [3:0] res;
    sel   = idx - NIB_SETUP_FIRST;
    sbyte = SETUP_CMDS[sel[2:1]];
    cbyte = (cur == CUR_LINE2) ? CMD_LINE2 : CMD_LINE1;
    res   = 4'h0;
    case (idx)
      NIB_INIT_FIRST, 4'd1: res = INIT_NIB_A;
      NIB_INIT_LAST:        res = INIT_NIB_B;
      NIB_CURSOR_HI:        res = cbyte[7:4];
      NIB_CURSOR_LO:        res = cbyte[3:0];
      NIB_DATA_HI:          res = ch[7:4];
      NIB_DATA_LO:          res = ch[3:0];
      default: begin
        if (idx >= NIB_SETUP_FIRST && idx <= NIB_SETUP_LAST) begin
          res = sel[0] ? sbyte[3:0] : sbyte[7:4];
        end
      end
    endcase
    return res;
  endfunction

endpackage

// ===== design/clpw_char_if.sv =====
`timescale 1ns / 1ps
interface clpw_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

// ===== design/clpw_exp_if.sv =====
`timescale 1ns / 1ps
interface clpw_exp_if;
  logic       valid;
  logic       ready;
  logic [7:0] expander_byte;
  logic       last_of_run;

  modport source (output valid, output expander_byte, output last_of_run, input ready);
  modport sink   (input valid, input expander_byte, input last_of_run, output ready);
endinterface

// ===== design/clpw_front.sv =====
`timescale 1ns / 1ps
module clpw_front #(
  parameter int CHARS_PER_LINE = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [7:0]    in_char_i,
  input  logic          q_full_i,
  output logic          in_ready_o,
  output logic          push_o,
  output clpw_pkg::desc_t push_desc_o
);
  import clpw_pkg::*;

  localparam int PW = $clog2(2 * CHARS_PER_LINE);
  localparam logic [PW-1:0] POS_LINE2 = PW'(CHARS_PER_LINE);
  localparam logic [PW-1:0] POS_LAST  = PW'(2 * CHARS_PER_LINE - 1);

  logic          init_done_q, init_done_d;
  logic [PW-1:0] pos_q, pos_d;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    push_desc_o.init   = !init_done_q;
    push_desc_o.cursor = CUR_NONE;
    if (pos_q == '0) begin
      push_desc_o.cursor = CUR_LINE1;
    end else if (pos_q == POS_LINE2) begin
      push_desc_o.cursor = CUR_LINE2;
    end
    push_desc_o.ch = (in_char_i == 8'h00) ? CHAR_SPACE : in_char_i;

    init_done_d = init_done_q;
    pos_d       = pos_q;
    if (push_o) begin
      init_done_d = 1'b1;
      pos_d       = (pos_q == POS_LAST) ? '0 : pos_q + PW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_done_q <= 1'b0;
      pos_q       <= '0;
    end else begin
      init_done_q <= init_done_d;
      pos_q       <= pos_d;
    end
  end
endmodule

// ===== design/clpw_queue.sv =====
`timescale 1ns / 1ps
module clpw_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  clpw_pkg::desc_t  push_desc_i,
  input  logic             pop_i,
  output logic             full_o,
  output clpw_pkg::q_stat_t stat_o
);
  import clpw_pkg::*;

  desc_t      mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o       = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign stat_o.head  = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? !wptr_q : wptr_q;
    rptr_d = pop_i  ? !rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end
endmodule

// ===== design/clpw_back.sv =====
`timescale 1ns / 1ps
module clpw_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              backlight_i,
  input  clpw_pkg::q_stat_t stat_i,
  output logic              pop_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [7:0]        out_byte_o,
  output logic              out_last_o
);
  import clpw_pkg::*;

  logic     active_q, active_d;
  nib_idx_t idx_q, idx_d;
  logic     elow_q, elow_d;
  logic     out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic     out_last_q, out_last_d;

  nib_idx_t   cur_idx, start_idx, nxt_idx;
  logic       cur_elow, is_last, load;
  logic [3:0] nib;

  always_comb begin
    if (stat_i.head.init) begin
      start_idx = NIB_INIT_FIRST;
    end else if (stat_i.head.cursor != CUR_NONE) begin
      start_idx = NIB_CURSOR_HI;
    end else begin
      start_idx = NIB_DATA_HI;
    end
    cur_idx  = active_q ? idx_q : start_idx;
    cur_elow = active_q && elow_q;
    is_last  = (cur_idx == NIB_DATA_LO) && cur_elow;
    nib      = nib_value(cur_idx, stat_i.head.cursor, stat_i.head.ch);

    nxt_idx = cur_idx + 4'd1;
    if (nxt_idx == NIB_CURSOR_HI && stat_i.head.cursor == CUR_NONE) begin
      nxt_idx = NIB_DATA_HI;
    end

    load  = !out_valid_q || out_ready_i;
    pop_o = load && !stat_i.empty && is_last;

    active_d    = active_q;
    idx_d       = idx_q;
    elow_d      = elow_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (load) begin
      out_valid_d = !stat_i.empty;
      out_byte_d  = {nib, backlight_i, !cur_elow, 1'b0, (cur_idx >= NIB_DATA_HI)};
      out_last_d  = is_last;
      if (!stat_i.empty) begin
        if (is_last) begin
          active_d = 1'b0;
        end else begin
          active_d = 1'b1;
          elow_d   = !cur_elow;
          idx_d    = cur_elow ? nxt_idx : cur_idx;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      idx_q       <= NIB_INIT_FIRST;
      elow_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      idx_q       <= idx_d;
      elow_q      <= elow_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end
endmodule

// ===== design/char_lcd_i2c_expander_writer.sv =====
`timescale 1ns / 1ps
// Character LCD writer for an I2C port expander, LCD in 4-bit mode. Each message
// character taken on char_i produces a run of expander bytes on exp_o, one byte per
// cycle while exp_o is ready, last_of_run marking the final byte of the run: 4 bytes
// for an ordinary character, 8 at the start of each line (cursor command first), 30
// for the first character after reset (initialisation and set-up commands first). The
// output sequencer emitting one byte a cycle sets the rate; a two-entry queue lets
// char_i keep taking characters while exp_o is stalled, until the queue is full.
// cfg_we_i/cfg_data_i write the backlight enable (reset 1).
module char_lcd_i2c_expander_writer #(
  parameter int CHARS_PER_LINE = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_data_i,
  clpw_char_if.sink  char_i,
  clpw_exp_if.source exp_o
);
  import clpw_pkg::*;

  logic    backlight_q;
  logic    q_full, push, pop;
  desc_t   push_desc;
  q_stat_t q_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      backlight_q <= 1'b1;
    end else if (cfg_we_i) begin
      backlight_q <= cfg_data_i;
    end
  end

  clpw_front #(
    .CHARS_PER_LINE(CHARS_PER_LINE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (char_i.valid),
    .in_char_i  (char_i.char_code),
    .q_full_i   (q_full),
    .in_ready_o (char_i.ready),
    .push_o     (push),
    .push_desc_o(push_desc)
  );

  clpw_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_desc_i(push_desc),
    .pop_i      (pop),
    .full_o     (q_full),
    .stat_o     (q_stat)
  );

  clpw_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .backlight_i(backlight_q),
    .stat_i     (q_stat),
    .pop_o      (pop),
    .out_ready_i(exp_o.ready),
    .out_valid_o(exp_o.valid),
    .out_byte_o (exp_o.expander_byte),
    .out_last_o (exp_o.last_of_run)
  );
endmodule

// ===== design/clpw_checker.sv =====
`timescale 1ns / 1ps
module clpw_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_last_i
);
  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i)
      && $stable(out_last_i))
    else $error("output changed while stalled");

  a_rw_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !out_byte_i[1])
    else $error("rw bit set");

  a_last_elow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_last_i |-> !out_byte_i[2])
    else $error("run ends with enable high");

  // enable pulse: a high transfer is followed at once by the matching low byte
  a_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_byte_i[2] |=> out_valid_i && !out_byte_i[2]
      && out_byte_i[7:4] == $past(out_byte_i[7:4]))
    else $error("enable pulse broken");
endmodule

bind char_lcd_i2c_expander_writer clpw_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(exp_o.valid),
  .out_ready_i(exp_o.ready),
  .out_byte_i (exp_o.expander_byte),
  .out_last_i (exp_o.last_of_run)
);
